// ----- design/mtk_pkg.sv -----
// ----------------------------------------------------------------------------
// mtk_pkg: shared types, constants and key functions
// Character codes, key table and the result-queue push type used by the
// multi-tap keypad letter entry unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mtk_pkg;

  localparam int unsigned KEY_BITS_DEF  = 16;
  localparam int unsigned KEY_TABLE_LEN = 16;
  localparam int unsigned CHAR_W        = 7;
  localparam int unsigned TIMEOUT_W     = 16;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX   = 16'hFFFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 1'b1;

  // Command codes
  localparam logic CMD_POLL = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NONE  = 7'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_ONE   = 7'h31;
  localparam logic [CHAR_W-1:0] CH_STAR  = 7'h2A;
  localparam logic [CHAR_W-1:0] CH_HASH  = 7'h23;
  localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CH_C     = 7'h43;
  localparam logic [CHAR_W-1:0] CH_D     = 7'h44;
  localparam logic [CHAR_W-1:0] CH_F     = 7'h46;
  localparam logic [CHAR_W-1:0] CH_G     = 7'h47;
  localparam logic [CHAR_W-1:0] CH_I     = 7'h49;
  localparam logic [CHAR_W-1:0] CH_J     = 7'h4A;
  localparam logic [CHAR_W-1:0] CH_L     = 7'h4C;
  localparam logic [CHAR_W-1:0] CH_M     = 7'h4D;
  localparam logic [CHAR_W-1:0] CH_O     = 7'h4F;
  localparam logic [CHAR_W-1:0] CH_P     = 7'h50;
  localparam logic [CHAR_W-1:0] CH_S     = 7'h53;
  localparam logic [CHAR_W-1:0] CH_T     = 7'h54;
  localparam logic [CHAR_W-1:0] CH_V     = 7'h56;
  localparam logic [CHAR_W-1:0] CH_W     = 7'h57;
  localparam logic [CHAR_W-1:0] CH_Z     = 7'h5A;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } result_t;

  // Up to two results pushed by one request
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Character for each key bit; CH_NONE marks an unmapped bit
  function automatic logic [CHAR_W-1:0] key_char(input logic [3:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      4'd0:    c = CH_ZERO;
      4'd1:    c = CH_ONE;
      4'd2:    c = CH_A;
      4'd3:    c = CH_D;
      4'd4:    c = CH_G;
      4'd5:    c = CH_J;
      4'd6:    c = CH_M;
      4'd7:    c = CH_P;
      4'd8:    c = CH_T;
      4'd9:    c = CH_W;
      4'd13:   c = CH_HASH;
      4'd15:   c = CH_STAR;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  // True when letter cur sits on the key whose first letter is first
  function automatic logic same_key(input logic [CHAR_W-1:0] cur,
                                    input logic [CHAR_W-1:0] first);
    logic [1:0]        span;
    logic              mapped;
    logic [CHAR_W-1:0] diff;
    mapped = 1'b1;
    span   = 2'd2;
    if (first == CH_P || first == CH_W) begin
      span = 2'd3;
    end else if (!(first == CH_A || first == CH_D || first == CH_G ||
                   first == CH_J || first == CH_M || first == CH_T)) begin
      mapped = 1'b0;
    end
    diff = cur - first;
    return mapped && (cur >= first) && (diff <= CHAR_W'(span));
  endfunction

  // Advance to the next letter of the same key, wrapping to its first
  function automatic logic [CHAR_W-1:0] next_letter(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] n;
    if (c == CH_C || c == CH_F || c == CH_I || c == CH_L || c == CH_O || c == CH_V) begin
      n = c - 7'd2;
    end else if (c == CH_S || c == CH_Z) begin
      n = c - 7'd3;
    end else begin
      n = c + 7'd1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- design/mtk_out_queue.sv -----
// ----------------------------------------------------------------------------
// mtk_out_queue: result queue
// Small queue that takes up to two results per cycle and hands out one while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mtk_out_queue (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push_en,
  input  wire mtk_pkg::push_t                  push,
  output logic                                 room,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output mtk_pkg::result_t                     head
);

  localparam int unsigned PTR_W = $clog2(mtk_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  mtk_pkg::result_t entries [mtk_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] push_n;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr_1;

  assign push_n    = push_en ? CNT_W'(push.count) : '0;
  assign pop       = out_valid && out_ready;
  assign wr_ptr_1  = wr_ptr + PTR_W'(1);
  assign out_valid = (count != '0);
  assign head      = entries[rd_ptr];
  // keep space for two results of the next request
  assign room      = (count <= CNT_W'(mtk_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + push_n - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_en && push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push_en && push.count == 2'd2) begin
      entries[wr_ptr_1] <= push.second;
    end
  end

endmodule

`default_nettype wire

// ----- design/multitap_keypad_letter_entry_unit.sv -----
// ----------------------------------------------------------------------------
// multitap_keypad_letter_entry_unit: multi-tap keypad text entry
// Turns keypad poll samples and millisecond ticks into ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per beat: cmd selects
//   a keypad poll sample (key_bits) or a one-millisecond tick. Output channel
//   (out_valid/out_ready) delivers characters in order; last marks the final
//   character caused by one request. A request causes zero, one or two
//   characters.
//   Order: state is updated at the accepting edge and the characters are
//   written into a four-entry result queue, behind any characters already
//   queued. Throughput: one request per cycle while the queue has room for
//   two results; the queue drains one character per cycle while out_ready is
//   high, so sustained rate is bounded by the characters produced.
//   Stalls: when out_ready is low the queue fills and in_ready drops once
//   fewer than two free entries remain; nothing is lost.
//   Reset: timeout 1000 ticks, entry enabled, nothing pending, previous sample
//   and elapsed count cleared, queue emptied.
//   Configuration: cfg_we writes register cfg_index (0 timeout, 1 enable)
//   from cfg_data at the clock edge; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module multitap_keypad_letter_entry_unit #(
  parameter int unsigned KEY_BITS = mtk_pkg::KEY_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [mtk_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mtk_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              cmd,
  input  wire logic [KEY_BITS-1:0]               key_bits,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [mtk_pkg::CHAR_W-1:0]             char_code,
  output logic                                   last
);

  localparam int unsigned IDX_W = $clog2(KEY_BITS);

  // Configuration registers
  logic [mtk_pkg::TIMEOUT_W-1:0] timeout_ticks;
  logic                          entry_enable;

  // Entry state
  logic [mtk_pkg::CHAR_W-1:0]    pending_char;
  logic [mtk_pkg::CHAR_W-1:0]    pending_char_next;
  logic [KEY_BITS-1:0]           previous_sample;
  logic [KEY_BITS-1:0]           previous_sample_next;
  logic [mtk_pkg::TIMEOUT_W-1:0] elapsed_ticks;
  logic [mtk_pkg::TIMEOUT_W-1:0] elapsed_ticks_next;

  logic                          in_fire;
  logic                          room;
  mtk_pkg::push_t                push;
  mtk_pkg::result_t              head;

  logic                          found;
  logic [IDX_W-1:0]              key_idx;
  logic [mtk_pkg::CHAR_W-1:0]    key_c;
  logic                          is_symbol;
  logic [mtk_pkg::TIMEOUT_W-1:0] elapsed_inc;
  logic [1:0]                    n;
  logic [mtk_pkg::CHAR_W-1:0]    e0;
  logic [mtk_pkg::CHAR_W-1:0]    e1;

  assign in_ready = room;
  assign in_fire  = in_valid && in_ready;

  // Lowest set bit selects the key
  always_comb begin
    found   = 1'b0;
    key_idx = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      if (!found && key_bits[i]) begin
        found   = 1'b1;
        key_idx = IDX_W'(i);
      end
    end
  end

  assign key_c     = found ? mtk_pkg::key_char(4'(key_idx)) : mtk_pkg::CH_NONE;
  assign is_symbol = (key_c == mtk_pkg::CH_ZERO) || (key_c == mtk_pkg::CH_ONE) ||
                     (key_c == mtk_pkg::CH_STAR) || (key_c == mtk_pkg::CH_HASH);
  // saturate the idle counter
  assign elapsed_inc = (elapsed_ticks == mtk_pkg::ELAPSED_MAX) ? elapsed_ticks
                                                               : elapsed_ticks + 16'd1;

  always_comb begin
    pending_char_next    = pending_char;
    previous_sample_next = previous_sample;
    elapsed_ticks_next   = elapsed_ticks;
    n  = 2'd0;
    e0 = pending_char;
    e1 = key_c;
    if (cmd == mtk_pkg::CMD_TICK) begin
      elapsed_ticks_next = elapsed_inc;
      // flush the pending letter once idle time strictly exceeds the timeout
      if (entry_enable && pending_char != mtk_pkg::CH_NONE && elapsed_inc > timeout_ticks) begin
        n = 2'd1;
        pending_char_next = mtk_pkg::CH_NONE;
      end
    end else if (entry_enable) begin
      if (key_bits != previous_sample && key_bits != '0) begin
        elapsed_ticks_next = '0;
        if (is_symbol) begin
          // flush the pending letter, then the symbol itself
          if (pending_char != mtk_pkg::CH_NONE) begin
            n = 2'd2;
          end else begin
            n  = 2'd1;
            e0 = key_c;
          end
          pending_char_next = mtk_pkg::CH_NONE;
        end else if (pending_char == mtk_pkg::CH_NONE) begin
          pending_char_next = key_c;
        end else if (mtk_pkg::same_key(pending_char, key_c)) begin
          pending_char_next = mtk_pkg::next_letter(pending_char);
        end else begin
          // other key or unmapped bit: emit what was pending
          n = 2'd1;
          pending_char_next = key_c;
        end
      end
      previous_sample_next = key_bits;
    end
  end

  always_comb begin
    push.count            = n;
    push.first.char_code  = e0;
    push.first.last       = (n == 2'd1);
    push.second.char_code = e1;
    push.second.last      = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks   <= mtk_pkg::TIMEOUT_RESET;
      entry_enable    <= 1'b1;
      pending_char    <= mtk_pkg::CH_NONE;
      previous_sample <= '0;
      elapsed_ticks   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mtk_pkg::REG_TIMEOUT: timeout_ticks <= cfg_data;
          mtk_pkg::REG_ENABLE:  entry_enable  <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_fire) begin
        pending_char    <= pending_char_next;
        previous_sample <= previous_sample_next;
        elapsed_ticks   <= elapsed_ticks_next;
      end
    end
  end

  mtk_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (in_fire),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign char_code = head.char_code;
  assign last      = head.last;

  // Assertions

  // after any result is pushed, the output must be valid the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && n != 2'd0) |=> out_valid)
    else $error("pushed result not visible at output");

  // a pending letter is always an uppercase letter
  assert property (@(posedge clk) disable iff (rst)
    (pending_char != mtk_pkg::CH_NONE) |->
      (pending_char >= mtk_pkg::CH_A && pending_char <= mtk_pkg::CH_Z))
    else $error("pending character is not a letter");

  // a tick advances the idle counter by one until saturation
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && cmd == mtk_pkg::CMD_TICK && elapsed_ticks != mtk_pkg::ELAPSED_MAX) |=>
      (elapsed_ticks == $past(elapsed_ticks) + 16'd1))
    else $error("idle counter did not advance on tick");

  // two results only come from a symbol key press
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && n == 2'd2) |-> (cmd == mtk_pkg::CMD_POLL && is_symbol))
    else $error("two results from a request that is not a symbol press");

endmodule

`default_nettype wire

// ----- tb/sv/multitap_keypad_letter_entry_unit_tb.sv -----
// ----------------------------------------------------------------------------
// multitap_keypad_letter_entry_unit_tb: self-checking bench for multi-tap entry
// Drives keypad poll samples and millisecond ticks through the request channel
// and checks every emitted character against a cycle-free predictor of the
// multi-tap letter logic. A directed table comes first, then random key runs,
// tick runs and noise under several timeout and enable settings.
// ----------------------------------------------------------------------------
module multitap_keypad_letter_entry_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Key bit positions on the keypad matrix
  localparam int unsigned KB_ZERO        = 0;
  localparam int unsigned KB_ONE         = 1;
  localparam int unsigned KB_ABC         = 2;
  localparam int unsigned KB_DEF         = 3;
  localparam int unsigned KB_GHI         = 4;
  localparam int unsigned KB_JKL         = 5;
  localparam int unsigned KB_MNO         = 6;
  localparam int unsigned KB_PQRS        = 7;
  localparam int unsigned KB_TUV         = 8;
  localparam int unsigned KB_WXYZ        = 9;
  localparam int unsigned KB_UNMAPPED_10 = 10;
  localparam int unsigned KB_UNMAPPED_11 = 11;
  localparam int unsigned KB_UNMAPPED_12 = 12;
  localparam int unsigned KB_HASH        = 13;
  localparam int unsigned KB_UNMAPPED_14 = 14;
  localparam int unsigned KB_STAR        = 15;

  localparam logic [15:0] K_ZERO        = 16'd1 << KB_ZERO;
  localparam logic [15:0] K_ONE         = 16'd1 << KB_ONE;
  localparam logic [15:0] K_ABC         = 16'd1 << KB_ABC;
  localparam logic [15:0] K_DEF         = 16'd1 << KB_DEF;
  localparam logic [15:0] K_GHI         = 16'd1 << KB_GHI;
  localparam logic [15:0] K_PQRS        = 16'd1 << KB_PQRS;
  localparam logic [15:0] K_TUV         = 16'd1 << KB_TUV;
  localparam logic [15:0] K_WXYZ        = 16'd1 << KB_WXYZ;
  localparam logic [15:0] K_UNMAPPED_10 = 16'd1 << KB_UNMAPPED_10;
  localparam logic [15:0] K_UNMAPPED_11 = 16'd1 << KB_UNMAPPED_11;
  localparam logic [15:0] K_UNMAPPED_12 = 16'd1 << KB_UNMAPPED_12;
  localparam logic [15:0] K_HASH        = 16'd1 << KB_HASH;
  localparam logic [15:0] K_UNMAPPED_14 = 16'd1 << KB_UNMAPPED_14;
  localparam logic [15:0] K_STAR        = 16'd1 << KB_STAR;

  localparam int unsigned PHASE_REQUESTS = 132;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // One row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    logic        op;
    logic [15:0] sample;
    logic        typed;
    logic [1:0]  n_chars;
    logic [6:0]  ch_a;
    logic [6:0]  ch_b;
  } stim_row_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [0:0]  cfg_index = mtk_pkg::REG_TIMEOUT;
  logic [15:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        cmd       = mtk_pkg::CMD_POLL;
  logic [15:0] key_bits  = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  char_code;
  logic        last;

  // Predictor state: a private copy of the registers and the entry state
  logic [15:0] timeout_cfg;
  logic        entry_on;
  logic [6:0]  pending_letter;
  logic [15:0] prev_sample;
  logic [15:0] ticks_since_press;

  mtk_pkg::result_t expected_chars[$];
  stim_row_t        directed_rows[$];

  int unsigned fail_count    = 0;
  int unsigned chars_checked = 0;
  int unsigned requests_sent = 0;
  int unsigned reg_writes    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned burst_left    = 0;
  bit          pace_gaps     = 1'b1;

  multitap_keypad_letter_entry_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .key_bits  (key_bits),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Character selected by the lowest set bit; CH_NONE for unmapped bits
  function automatic logic [6:0] char_for_sample(input logic [15:0] sample);
    int unsigned idx;
    idx = 16;
    for (int i = 15; i >= 0; i--) begin
      if (sample[i]) idx = i;
    end
    case (idx)
      KB_ZERO: return mtk_pkg::CH_ZERO;
      KB_ONE:  return mtk_pkg::CH_ONE;
      KB_ABC:  return mtk_pkg::CH_A;
      KB_DEF:  return mtk_pkg::CH_D;
      KB_GHI:  return mtk_pkg::CH_G;
      KB_JKL:  return mtk_pkg::CH_J;
      KB_MNO:  return mtk_pkg::CH_M;
      KB_PQRS: return mtk_pkg::CH_P;
      KB_TUV:  return mtk_pkg::CH_T;
      KB_WXYZ: return mtk_pkg::CH_W;
      KB_HASH: return mtk_pkg::CH_HASH;
      KB_STAR: return mtk_pkg::CH_STAR;
      default: return mtk_pkg::CH_NONE;
    endcase
  endfunction

  // First letter of the key that carries letter c
  function automatic logic [6:0] key_first_letter(input logic [6:0] c);
    if (c >= mtk_pkg::CH_W) return mtk_pkg::CH_W;
    if (c >= mtk_pkg::CH_T) return mtk_pkg::CH_T;
    if (c >= mtk_pkg::CH_P) return mtk_pkg::CH_P;
    if (c >= mtk_pkg::CH_M) return mtk_pkg::CH_M;
    if (c >= mtk_pkg::CH_J) return mtk_pkg::CH_J;
    if (c >= mtk_pkg::CH_G) return mtk_pkg::CH_G;
    if (c >= mtk_pkg::CH_D) return mtk_pkg::CH_D;
    return mtk_pkg::CH_A;
  endfunction

  // Step to the next letter on the same key, wrapping after the last one
  function automatic logic [6:0] cycle_letter(input logic [6:0] c);
    logic [6:0] first;
    logic [6:0] top;
    first = key_first_letter(c);
    top   = (first == mtk_pkg::CH_P || first == mtk_pkg::CH_W) ? first + 7'd3
                                                               : first + 7'd2;
    return (c == top) ? first : c + 7'd1;
  endfunction

  // Advance the entry state by one request; return the number of characters
  function automatic int predict_keypad_chars(input logic op, input logic [15:0] sample,
                                              output logic [6:0] ch_a,
                                              output logic [6:0] ch_b);
    int         n;
    logic [6:0] key_ch;
    n    = 0;
    ch_a = mtk_pkg::CH_NONE;
    ch_b = mtk_pkg::CH_NONE;
    if (op == mtk_pkg::CMD_TICK) begin
      // the counter runs even while entry is off, and stops at its ceiling
      if (ticks_since_press != mtk_pkg::ELAPSED_MAX) begin
        ticks_since_press = ticks_since_press + 16'd1;
      end
      if (entry_on && pending_letter != mtk_pkg::CH_NONE &&
          ticks_since_press > timeout_cfg) begin
        ch_a           = pending_letter;
        n              = 1;
        pending_letter = mtk_pkg::CH_NONE;
      end
    end else if (entry_on) begin
      if (sample != prev_sample && sample != 16'd0) begin
        key_ch = char_for_sample(sample);
        if (key_ch == mtk_pkg::CH_ZERO || key_ch == mtk_pkg::CH_ONE ||
            key_ch == mtk_pkg::CH_STAR || key_ch == mtk_pkg::CH_HASH) begin
          // flush the letter in progress, then the symbol key itself
          if (pending_letter != mtk_pkg::CH_NONE) begin
            ch_a = pending_letter;
            ch_b = key_ch;
            n    = 2;
          end else begin
            ch_a = key_ch;
            n    = 1;
          end
          pending_letter = mtk_pkg::CH_NONE;
        end else if (pending_letter == mtk_pkg::CH_NONE) begin
          pending_letter = key_ch;
        end else if (key_ch != mtk_pkg::CH_NONE &&
                     key_first_letter(pending_letter) == key_ch) begin
          pending_letter = cycle_letter(pending_letter);
        end else begin
          // another key or an unmapped one: emit and start over
          ch_a           = pending_letter;
          n              = 1;
          pending_letter = key_ch;
        end
        ticks_since_press = 16'd0;
      end
      prev_sample = sample;
    end
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver, register writes and idling
  // --------------------------------------------------------------------------

  // Present one request, hold it until accepted, then queue its characters.
  // Called at a rising edge; returns at the edge that accepted the request.
  task automatic send_request(input logic op, input logic [15:0] sample,
                              input logic typed = 1'b0,
                              input logic [1:0] n_chars = 2'd0,
                              input logic [6:0] ch_a = mtk_pkg::CH_NONE,
                              input logic [6:0] ch_b = mtk_pkg::CH_NONE);
    int unsigned gap;
    int          n;
    logic [6:0]  pa;
    logic [6:0]  pb;
    gap = 0;
    if (pace_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 1);
        gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    key_bits <= sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    n = predict_keypad_chars(op, sample, pa, pb);
    // typed rows override the prediction with the hand-written expectation
    if (typed) begin
      n  = n_chars;
      pa = ch_a;
      pb = ch_b;
    end
    if (n == 1) begin
      expected_chars.push_back('{char_code: pa, last: 1'b1});
    end else if (n == 2) begin
      expected_chars.push_back('{char_code: pa, last: 1'b0});
      expected_chars.push_back('{char_code: pb, last: 1'b1});
    end
  endtask

  // Drop valid and hold until every queued character has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the timeout register, then the enable register; the block must be idle
  task automatic write_regs(input logic [15:0] timeout_val, input logic [15:0] enable_word);
    cfg_we    <= 1'b1;
    cfg_index <= mtk_pkg::REG_TIMEOUT;
    cfg_data  <= timeout_val;
    @(posedge clk);
    timeout_cfg = timeout_val;
    cfg_index <= mtk_pkg::REG_ENABLE;
    cfg_data  <= enable_word;
    @(posedge clk);
    entry_on = enable_word[0];
    cfg_we <= 1'b0;
    reg_writes += 2;
  endtask

  function automatic int unsigned pick_key_bit();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll < 7) return $urandom_range(KB_WXYZ, KB_ABC);
    if (roll < 9) begin
      case ($urandom_range(3))
        0:       return KB_ZERO;
        1:       return KB_ONE;
        2:       return KB_HASH;
        default: return KB_STAR;
      endcase
    end
    case ($urandom_range(3))
      0:       return KB_UNMAPPED_10;
      1:       return KB_UNMAPPED_11;
      2:       return KB_UNMAPPED_12;
      default: return KB_UNMAPPED_14;
    endcase
  endfunction

  // Sample with key b as its lowest set bit, sometimes with junk above it
  function automatic logic [15:0] key_sample(input int unsigned b);
    logic [15:0] upper;
    upper = ($urandom_range(1) == 0) ? 16'd0 : (16'($urandom) << (b + 1));
    return upper | (16'd1 << b);
  endfunction

  // Configure, then mostly well-formed press runs and tick runs with noise.
  // Halfway through, pause the sender until everything has drained.
  task automatic run_phase(input logic [15:0] timeout_val, input logic enable_bit);
    int unsigned start;
    int unsigned roll;
    int unsigned b;
    int unsigned presses;
    int unsigned lim;
    bit          paused;
    drain_results();
    write_regs(timeout_val, {15'($urandom), enable_bit});
    start  = requests_sent;
    paused = 1'b0;
    while (requests_sent - start < PHASE_REQUESTS) begin
      if (!paused && requests_sent - start >= PHASE_REQUESTS / 2) begin
        drain_results();
        paused = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 55) begin
        b       = pick_key_bit();
        presses = (b >= KB_ABC && b <= KB_WXYZ) ? $urandom_range(6, 1) : 1;
        repeat (presses) begin
          send_request(mtk_pkg::CMD_POLL, key_sample(b));
          // release the key most of the time so the next press is a new sample
          if ($urandom_range(3) != 0) send_request(mtk_pkg::CMD_POLL, 16'd0);
        end
      end else if (roll < 80) begin
        lim = (timeout_cfg < 16'd10) ? int'(timeout_cfg) + 3 : 12;
        repeat ($urandom_range(lim, 1)) send_request(mtk_pkg::CMD_TICK, 16'($urandom));
      end else begin
        send_request(1'($urandom_range(1)), 16'($urandom));
      end
    end
  endtask

  // Receiver: switch between always ready, coin-flip ready and stall bursts
  initial begin
    int unsigned mode;
    int unsigned span_len;
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      mode     = $urandom_range(2);
      span_len = $urandom_range(200, 32);
      repeat (span_len) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(1));
          default: begin
            if (stall_left > 0) begin
              out_ready <= 1'b0;
              stall_left--;
            end else begin
              out_ready <= 1'b1;
              if ($urandom_range(3) == 0) stall_left = $urandom_range(12, 1);
            end
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker and watchdog
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    mtk_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, got char_code %h last %b",
                 $time, char_code, last);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (char_code !== want.char_code) begin
          $display("%0t: char_code mismatch: expected %h, got %h",
                   $time, want.char_code, char_code);
          fail_count++;
        end
        if (last !== want.last) begin
          $display("%0t: last mismatch: expected %b, got %b", $time, want.last, last);
          fail_count++;
        end
      end
    end
  end

  // Count cycles with no handshake on either side; give up past the limit
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d characters still owed",
               $time, WATCHDOG_LIMIT, expected_chars.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------

  function automatic void add_row(input logic op, input logic [15:0] sample,
                                  input logic typed, input logic [1:0] n_chars,
                                  input logic [6:0] ch_a, input logic [6:0] ch_b);
    directed_rows.push_back('{op: op, sample: sample, typed: typed, n_chars: n_chars,
                              ch_a: ch_a, ch_b: ch_b});
  endfunction

  initial begin
    // reset values of registers and entry state
    timeout_cfg       = mtk_pkg::TIMEOUT_RESET;
    entry_on          = 1'b1;
    pending_letter    = mtk_pkg::CH_NONE;
    prev_sample       = 16'd0;
    ticks_since_press = 16'd0;

    // Directed table, run at the reset settings (timeout 1000, entry on)
    // zero sample is no press
    add_row(mtk_pkg::CMD_POLL, 16'd0, 1'b1, 2'd0, mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, K_ZERO, 1'b1, 2'd1, mtk_pkg::CH_ZERO, mtk_pkg::CH_NONE);
    // held key repeats nothing
    add_row(mtk_pkg::CMD_POLL, K_ZERO, 1'b1, 2'd0, mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, K_ONE, 1'b1, 2'd1, mtk_pkg::CH_ONE, mtk_pkg::CH_NONE);
    // cycle A B C and wrap
    add_row(mtk_pkg::CMD_POLL, K_ABC, 1'b0, 2'd0, mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, 16'd0, 1'b0, 2'd0, mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, K_ABC, 1'b0, 2'd0, mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, 16'd0, 1'b0, 2'd0, mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, K_ABC, 1'b0, 2'd0, mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, 16'd0, 1'b0, 2'd0, mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, K_ABC, 1'b0, 2'd0, mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    // other key flushes A
    add_row(mtk_pkg::CMD_POLL, K_PQRS, 1'b0, 2'd0, mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, K_STAR, 1'b1, 2'd2, mtk_pkg::CH_P, mtk_pkg::CH_STAR);
    add_row(mtk_pkg::CMD_POLL, K_HASH, 1'b1, 2'd1, mtk_pkg::CH_HASH, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, K_UNMAPPED_10, 1'b1, 2'd0,
            mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, K_WXYZ, 1'b0, 2'd0, mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    // lowest bit wins
    add_row(mtk_pkg::CMD_POLL, 16'hFFFF, 1'b1, 2'd2, mtk_pkg::CH_W, mtk_pkg::CH_ZERO);
    add_row(mtk_pkg::CMD_POLL, K_UNMAPPED_14, 1'b1, 2'd0,
            mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, K_TUV, 1'b0, 2'd0, mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, K_UNMAPPED_12 | K_UNMAPPED_14, 1'b1, 2'd1,
            mtk_pkg::CH_T, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, K_UNMAPPED_11, 1'b1, 2'd0,
            mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, 16'hFFFE, 1'b1, 2'd1, mtk_pkg::CH_ONE, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, K_DEF, 1'b0, 2'd0, mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    // far below the timeout
    add_row(mtk_pkg::CMD_TICK, 16'hFFFF, 1'b1, 2'd0, mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);
    add_row(mtk_pkg::CMD_POLL, K_GHI, 1'b0, 2'd0, mtk_pkg::CH_NONE, mtk_pkg::CH_NONE);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].sample, directed_rows[i].typed,
                   directed_rows[i].n_chars, directed_rows[i].ch_a, directed_rows[i].ch_b);
    end

    // Random phases across timeout and enable settings, extremes included
    run_phase(16'd4, 1'b1);
    run_phase(16'd0, 1'b1);
    run_phase(16'd2, 1'b0);
    run_phase(16'd1, 1'b1);
    run_phase(mtk_pkg::ELAPSED_MAX, 1'b1);
    run_phase(16'd9, 1'b1);
    run_phase(16'd3, 1'b1);

    // Wait out the tail so a stray extra character is still caught
    drain_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d requests (%0d directed) and %0d characters, %0d register writes",
             requests_sent, directed_rows.size(), chars_checked, reg_writes);
    $display("timeouts 0 to 65535 ticks, entry on and off, receiver stalls and paused sender");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/mtk_pkg.sv
design/mtk_out_queue.sv
design/multitap_keypad_letter_entry_unit.sv
tb/sv/multitap_keypad_letter_entry_unit_tb.sv
